// ===== hdl/two_button_press_classifier_macros.svh =====
// Assertion macros used by the two-button press classifier top level.
`ifndef TWO_BUTTON_PRESS_CLASSIFIER_MACROS_SVH
`define TWO_BUTTON_PRESS_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TBPC_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TBPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/tbpc_pkg.sv =====
// Shared types, register map and event codes of the two-button press classifier.
`timescale 1ns / 1ps

package tbpc_pkg;

   // Default width of the wrapping millisecond time arithmetic
   localparam int TIME_BITS_DEFAULT = 32;

   // Configuration port geometry
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // Register indexes (byte address = 4 * index)
   localparam logic [1:0] REG_DEBOUNCE_MS    = 2'd0;
   localparam logic [1:0] REG_LONG_PRESS_MS  = 2'd1;
   localparam logic [1:0] REG_BOTH_WINDOW_MS = 2'd2;
   localparam logic [1:0] REG_INVERT_LEVELS  = 2'd3;

   // Register reset values
   localparam logic [15:0] DEBOUNCE_MS_RESET    = 16'd50;
   localparam logic [15:0] LONG_PRESS_MS_RESET  = 16'd1000;
   localparam logic [15:0] BOTH_WINDOW_MS_RESET = 16'd200;

   typedef enum logic [2:0] {
      EV_NONE      = 3'd0,
      EV_BOTH_LONG = 3'd1,
      EV_LONG_ONE  = 3'd2,
      EV_LONG_TWO  = 3'd3,
      EV_SHORT_ONE = 3'd4,
      EV_SHORT_TWO = 3'd5
   } event_code_type;

   typedef struct packed {
      logic [15:0] debounce_ms;
      logic [15:0] long_press_ms;
      logic [15:0] both_window_ms;
      logic        invert_levels;
   } config_type;

   // Per-button outcome of this poll's debounce step
   typedef struct packed {
      logic changed;   // level change taken on this poll
      logic stable;    // debounced level after this poll
      logic flag;      // pressed flag before event consumption
   } button_status_type;

   // Classifier decision
   typedef struct packed {
      event_code_type code;
      logic           clear_one;
      logic           clear_two;
   } verdict_type;

endpackage

// ===== hdl/tbpc_csr.sv =====
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps

module tbpc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [tbpc_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [tbpc_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [tbpc_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                              pready,
   output tbpc_pkg::config_type              config_out
);
   import tbpc_pkg::*;

   config_type cfg_ff;
   logic [1:0] reg_index;
   logic       write_transfer;

   assign reg_index      = paddr[3:2];
   assign write_transfer = psel && penable && pwrite;
   assign pready         = 1'b1;
   assign config_out     = cfg_ff;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms    <= DEBOUNCE_MS_RESET;
         cfg_ff.long_press_ms  <= LONG_PRESS_MS_RESET;
         cfg_ff.both_window_ms <= BOTH_WINDOW_MS_RESET;
         cfg_ff.invert_levels  <= 1'b0;
      end else if (write_transfer) begin
         unique case (reg_index)
            REG_DEBOUNCE_MS:    cfg_ff.debounce_ms    <= pwdata[15:0];
            REG_LONG_PRESS_MS:  cfg_ff.long_press_ms  <= pwdata[15:0];
            REG_BOTH_WINDOW_MS: cfg_ff.both_window_ms <= pwdata[15:0];
            REG_INVERT_LEVELS:  cfg_ff.invert_levels  <= pwdata[0];
            default: ;
         endcase
      end
   end

   // Read-back mux
   always_comb begin
      unique case (reg_index)
         REG_DEBOUNCE_MS:    prdata = CSR_DATA_BITS'(cfg_ff.debounce_ms);
         REG_LONG_PRESS_MS:  prdata = CSR_DATA_BITS'(cfg_ff.long_press_ms);
         REG_BOTH_WINDOW_MS: prdata = CSR_DATA_BITS'(cfg_ff.both_window_ms);
         REG_INVERT_LEVELS:  prdata = CSR_DATA_BITS'(cfg_ff.invert_levels);
         default:            prdata = '0;
      endcase
   end

endmodule

// ===== hdl/tbpc_button.sv =====
// Debounce and press-tracking state of one button.
`timescale 1ns / 1ps

module tbpc_button #(
   parameter int TIME_BITS = tbpc_pkg::TIME_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          update,      // commit this poll
   input  logic                          level,       // level after inversion
   input  logic [TIME_BITS-1:0]          now,
   input  logic [15:0]                   debounce_ms,
   input  logic                          clear_flag,  // press consumed by a long event
   output tbpc_pkg::button_status_type   status,
   output logic [TIME_BITS-1:0]          start_time
);
   import tbpc_pkg::*;

   logic                 stable_ff, stable_in;
   logic                 last_raw_ff;
   logic                 flag_ff, flag_in;
   logic [TIME_BITS-1:0] last_change_ff, last_change_in;
   logic [TIME_BITS-1:0] start_ff, start_in;
   logic [TIME_BITS-1:0] since_change;
   logic                 changed;

   // Debounce: level moved and more than the debounce time since the last change
   assign since_change = now - last_change_ff;
   assign changed      = (level != last_raw_ff) &&
                         (since_change > TIME_BITS'(debounce_ms));

   always_comb begin
      stable_in      = changed ? level : stable_ff;
      last_change_in = changed ? now : last_change_ff;
      start_in       = (changed && level) ? now : start_ff;
      flag_in        = changed ? level : flag_ff;
   end

   assign status.changed = changed;
   assign status.stable  = stable_in;
   assign status.flag    = flag_in;
   assign start_time     = start_in;

   // State commit on each processed poll
   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff      <= 1'b0;
         last_raw_ff    <= 1'b0;
         flag_ff        <= 1'b0;
         last_change_ff <= '0;
         start_ff       <= '0;
      end else if (update) begin
         stable_ff      <= stable_in;
         last_raw_ff    <= level;
         flag_ff        <= flag_in && !clear_flag;
         last_change_ff <= last_change_in;
         start_ff       <= start_in;
      end
   end

endmodule

// ===== hdl/tbpc_classify.sv =====
// Event priority logic: joint long, single long, then short press.
`timescale 1ns / 1ps

module tbpc_classify #(
   parameter int TIME_BITS = tbpc_pkg::TIME_BITS_DEFAULT
) (
   input  tbpc_pkg::button_status_type status_one,
   input  tbpc_pkg::button_status_type status_two,
   input  logic [TIME_BITS-1:0]        start_one,
   input  logic [TIME_BITS-1:0]        start_two,
   input  logic [TIME_BITS-1:0]        now,
   input  logic [15:0]                 long_press_ms,
   input  logic [15:0]                 both_window_ms,
   output tbpc_pkg::verdict_type       verdict
);
   import tbpc_pkg::*;

   logic [TIME_BITS-1:0] hold_one, hold_two;
   logic [TIME_BITS-1:0] start_gap, start_dist;
   logic [TIME_BITS-1:0] long_lim;
   logic                 long_one, long_two, in_window;

   assign long_lim = TIME_BITS'(long_press_ms);
   assign hold_one = now - start_one;
   assign hold_two = now - start_two;

   // Circular distance between the press starts; the half-range tie stays as is
   assign start_gap  = start_one - start_two;
   assign start_dist = start_gap[TIME_BITS-1] ? (TIME_BITS'(0) - start_gap) : start_gap;
   assign in_window  = start_dist <= TIME_BITS'(both_window_ms);

   assign long_one = status_one.flag && (hold_one > long_lim);
   assign long_two = status_two.flag && (hold_two > long_lim);

   always_comb begin
      verdict.code      = EV_NONE;
      verdict.clear_one = 1'b0;
      verdict.clear_two = 1'b0;
      priority if (long_one && long_two && in_window) begin
         verdict.code      = EV_BOTH_LONG;
         verdict.clear_one = 1'b1;
         verdict.clear_two = 1'b1;
      end else if (long_one && !status_two.flag) begin
         verdict.code      = EV_LONG_ONE;
         verdict.clear_one = 1'b1;
      end else if (long_two && !status_one.flag) begin
         verdict.code      = EV_LONG_TWO;
         verdict.clear_two = 1'b1;
      end else if (status_one.changed && !status_one.stable && hold_one < long_lim) begin
         verdict.code = EV_SHORT_ONE;
      end else if (status_two.changed && !status_two.stable && hold_two < long_lim) begin
         verdict.code = EV_SHORT_TWO;
      end else begin
         verdict.code = EV_NONE;
      end
   end

endmodule

// ===== hdl/two_button_press_classifier.sv =====
// Top level of the two-button debouncer and press classifier.
`timescale 1ns / 1ps
`include "two_button_press_classifier_macros.svh"

// Two-button press classifier. Each poll transfer carries two raw button
// levels and a free-running millisecond time; each poll gives exactly one
// result with an event code (none, both long, long one, long two, short one,
// short two) and the two pressed flags. One poll is taken every clock cycle
// unless req_stall holds it back; a taken poll sits in the input register,
// and its result is loaded into the result register when that register is
// free or drains, and is offered from there. The debounce, hold-time and
// window compares all sit in the single stage between the two registers,
// which also commits the per-button state. Time arithmetic wraps modulo
// 2^TIME_BITS. Registers are to be written by the user over the APB-style
// port only while no poll is in flight; the block does not enforce this.
module two_button_press_classifier #(
   parameter int TIME_BITS = tbpc_pkg::TIME_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // Poll channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_raw_level_one,
   input  logic                              req_raw_level_two,
   input  logic [31:0]                       req_now_ms,
   // Result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [2:0]                        rsp_event_code,
   output logic                              rsp_held_one,
   output logic                              rsp_held_two,
   // Configuration port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [tbpc_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [tbpc_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [tbpc_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                              pready
);
   import tbpc_pkg::*;

   config_type           cfg;
   logic                 in_valid_ff, in_valid_in;
   logic                 raw_one_ff, raw_two_ff;
   logic [31:0]          now_raw_ff;
   logic [TIME_BITS-1:0] now;
   logic                 advance, req_transfer;
   button_status_type    status_one, status_two;
   logic [TIME_BITS-1:0] start_one, start_two;
   verdict_type          verdict;
   logic                 out_valid_ff;
   event_code_type       event_ff;
   logic                 held_one_ff, held_two_ff;

   tbpc_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .config_out (cfg)
   );

   // Handshake: the stage moves when the result register is free or drains
   assign advance      = !out_valid_ff || !rsp_stall;
   assign req_stall    = in_valid_ff && !advance;
   assign req_transfer = req_valid && !req_stall;
   assign in_valid_in  = req_transfer || (in_valid_ff && !advance);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer) begin
         raw_one_ff <= req_raw_level_one;
         raw_two_ff <= req_raw_level_two;
         now_raw_ff <= req_now_ms;
      end
   end

   assign now = TIME_BITS'(now_raw_ff);

   tbpc_button #(.TIME_BITS(TIME_BITS)) u_button_one (
      .clock       (clock),
      .reset       (reset),
      .update      (in_valid_ff && advance),
      .level       (raw_one_ff ^ cfg.invert_levels),
      .now         (now),
      .debounce_ms (cfg.debounce_ms),
      .clear_flag  (verdict.clear_one),
      .status      (status_one),
      .start_time  (start_one)
   );

   tbpc_button #(.TIME_BITS(TIME_BITS)) u_button_two (
      .clock       (clock),
      .reset       (reset),
      .update      (in_valid_ff && advance),
      .level       (raw_two_ff ^ cfg.invert_levels),
      .now         (now),
      .debounce_ms (cfg.debounce_ms),
      .clear_flag  (verdict.clear_two),
      .status      (status_two),
      .start_time  (start_two)
   );

   tbpc_classify #(.TIME_BITS(TIME_BITS)) u_classify (
      .status_one     (status_one),
      .status_two     (status_two),
      .start_one      (start_one),
      .start_two      (start_two),
      .now            (now),
      .long_press_ms  (cfg.long_press_ms),
      .both_window_ms (cfg.both_window_ms),
      .verdict        (verdict)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         event_ff    <= verdict.code;
         held_one_ff <= status_one.flag && !verdict.clear_one;
         held_two_ff <= status_two.flag && !verdict.clear_two;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_event_code = event_ff;
   assign rsp_held_one   = held_one_ff;
   assign rsp_held_two   = held_two_ff;

   // A joint long press consumes both presses
   `TBPC_ASSERT_IMPLIES(a_both_long_clears, clock, reset, rsp_valid && (event_ff == EV_BOTH_LONG), !rsp_held_one && !rsp_held_two, "both-long event left a pressed flag set")
   // A single long press of one button leaves neither flag set
   `TBPC_ASSERT_IMPLIES(a_single_long_clears, clock, reset, rsp_valid && ((event_ff == EV_LONG_ONE) || (event_ff == EV_LONG_TWO)), !rsp_held_one && !rsp_held_two, "single long event left a pressed flag set")
   // Polls are only held back while the input register is occupied
   `TBPC_ASSERT_IMPLIES(a_stall_only_when_full, clock, reset, req_stall, in_valid_ff, "poll stalled with empty input register")
   // A poll that moves on shows up as a result in the next cycle
   `TBPC_ASSERT_NEXT(a_poll_reaches_output, clock, reset, in_valid_ff && advance, out_valid_ff, "processed poll did not reach the result register")

endmodule

// ===== sim/tb_two_button_press_classifier.sv =====
// Self-checking testbench for the two-button press classifier: polls in, checked results out.
`timescale 1ns / 1ps

module tb_two_button_press_classifier;
   import tbpc_pkg::*;

   localparam int CYCLE_LIMIT      = 200000;
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int MAX_REPORTS      = 10;

   typedef struct {
      logic        one;
      logic        two;
      logic [31:0] now;
   } poll_item_type;

   typedef struct {
      event_code_type code;
      logic           held_one;
      logic           held_two;
   } press_result_type;

   // Clock, reset and block ports
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_raw_level_one = 1'b0;
   logic                      req_raw_level_two = 1'b0;
   logic [31:0]               req_now_ms = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [2:0]                rsp_event_code;
   logic                      rsp_held_one;
   logic                      rsp_held_two;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]  paddr = '0;
   logic [CSR_DATA_BITS-1:0]  pwdata = '0;
   logic [CSR_DATA_BITS-1:0]  prdata;
   logic                      pready;

   // Stimulus and expectation stores
   poll_item_type    poll_queue[$];
   press_result_type expected_results[$];
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   int               holds_asked = 0;
   int               holds_served = 0;
   int               hold_left = 0;
   int               failures = 0;
   int               cycle_count = 0;
   logic [31:0]      sim_ms = '0;
   logic             intent[2];

   // Shadow of the registers and of the per-button state
   config_type       press_cfg;
   logic             debounced[2];
   logic             prev_raw[2];
   logic             armed[2];
   logic [31:0]      changed_at[2];
   logic [31:0]      pressed_at[2];
   press_result_type seen;

   two_button_press_classifier i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_raw_level_one (req_raw_level_one),
      .req_raw_level_two (req_raw_level_two),
      .req_now_ms        (req_now_ms),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_code    (rsp_event_code),
      .rsp_held_one      (rsp_held_one),
      .rsp_held_two      (rsp_held_two),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Wrapping millisecond difference
   function automatic logic [31:0] ms_since(input logic [31:0] later, input logic [31:0] earlier);
      return later - earlier;
   endfunction

   // Debounce one button; returns whether a change was taken on this poll
   function automatic logic take_sample(input int b, input logic level, input logic [31:0] now);
      logic taken;
      taken = 1'b0;
      if (level != prev_raw[b] && ms_since(now, changed_at[b]) > {16'd0, press_cfg.debounce_ms}) begin
         changed_at[b] = now;
         debounced[b]  = level;
         armed[b]      = level;
         if (level) begin
            pressed_at[b] = now;
         end
         taken = 1'b1;
      end
      prev_raw[b] = level;
      return taken;
   endfunction

   // Expected result of one poll, committing the shadow state
   function automatic press_result_type classify_poll(input logic raw_one, input logic raw_two,
                                                      input logic [31:0] now);
      logic             took[2];
      logic             long_one;
      logic             long_two;
      logic [31:0]      gap;
      logic [31:0]      long_ms;
      press_result_type res;
      long_ms = {16'd0, press_cfg.long_press_ms};
      took[0] = take_sample(0, raw_one ^ press_cfg.invert_levels, now);
      took[1] = take_sample(1, raw_two ^ press_cfg.invert_levels, now);
      long_one = armed[0] && ms_since(now, pressed_at[0]) > long_ms;
      long_two = armed[1] && ms_since(now, pressed_at[1]) > long_ms;
      // circular distance between the two press starts
      gap = ms_since(pressed_at[0], pressed_at[1]);
      if (gap[31]) begin
         gap = 32'd0 - gap;
      end
      if (gap == 32'd0 && pressed_at[0] != pressed_at[1]) begin
         gap = 32'h8000_0000;
      end
      res.code = EV_NONE;
      if (long_one && long_two && gap <= {16'd0, press_cfg.both_window_ms}) begin
         armed[0] = 1'b0;
         armed[1] = 1'b0;
         res.code = EV_BOTH_LONG;
      end else if (long_one && !armed[1]) begin
         armed[0] = 1'b0;
         res.code = EV_LONG_ONE;
      end else if (long_two && !armed[0]) begin
         armed[1] = 1'b0;
         res.code = EV_LONG_TWO;
      end else if (took[0] && !debounced[0] && ms_since(now, pressed_at[0]) < long_ms) begin
         res.code = EV_SHORT_ONE;
      end else if (took[1] && !debounced[1] && ms_since(now, pressed_at[1]) < long_ms) begin
         res.code = EV_SHORT_TWO;
      end
      res.held_one = armed[0];
      res.held_two = armed[1];
      return res;
   endfunction

   // Poll driver: predicts each accepted transfer, then offers the next item
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(classify_poll(req_raw_level_one, req_raw_level_two,
                                                     req_now_ms));
         end
         if (!req_valid || !req_stall) begin
            if (poll_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid         <= 1'b1;
               req_raw_level_one <= poll_queue[0].one;
               req_raw_level_two <= poll_queue[0].two;
               req_now_ms        <= poll_queue[0].now;
               void'(poll_queue.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic note_failure(input string what);
      failures++;
      if (failures <= MAX_REPORTS) begin
         $display("%s", what);
      end
   endtask

   // Result monitor: checks each transfer and drives stall, with an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               note_failure($sformatf("unexpected result: event %0d held %b%b",
                                      rsp_event_code, rsp_held_one, rsp_held_two));
            end else begin
               seen = expected_results.pop_front();
               if (rsp_event_code !== seen.code || rsp_held_one !== seen.held_one ||
                   rsp_held_two !== seen.held_two) begin
                  note_failure($sformatf("mismatch: event %0d held %b%b, expected event %0d held %b%b",
                                         rsp_event_code, rsp_held_one, rsp_held_two,
                                         seen.code, seen.held_one, seen.held_two));
               end
            end
         end
         if (hold_left == 0 && holds_served != holds_asked) begin
            holds_served++;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // Register write: setup then access phase
   task automatic write_register(input logic [1:0] index, input logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (index)
         REG_DEBOUNCE_MS:    press_cfg.debounce_ms    = value[15:0];
         REG_LONG_PRESS_MS:  press_cfg.long_press_ms  = value[15:0];
         REG_BOTH_WINDOW_MS: press_cfg.both_window_ms = value[15:0];
         REG_INVERT_LEVELS:  press_cfg.invert_levels  = value[0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [15:0] debounce, input logic [15:0] long_ms,
                                 input logic [15:0] window, input logic invert);
      write_register(REG_DEBOUNCE_MS, {16'd0, debounce});
      write_register(REG_LONG_PRESS_MS, {16'd0, long_ms});
      write_register(REG_BOTH_WINDOW_MS, {16'd0, window});
      write_register(REG_INVERT_LEVELS, {31'd0, invert});
   endtask

   // Sender pause: nothing queued, nothing offered, nothing outstanding
   task automatic wait_until_drained();
      do @(negedge clock);
      while (poll_queue.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic push_poll(input logic one, input logic two, input logic [31:0] now);
      poll_item_type item;
      item.one = one;
      item.two = two;
      item.now = now;
      poll_queue.push_back(item);
   endtask

   // Realistic button activity: slow presses with bounce, joint presses, rare jumps in time
   task automatic queue_button_activity(input int count, input int unsigned max_step);
      int unsigned pick;
      logic        one;
      logic        two;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 4) begin
            sim_ms = $urandom;
            one    = 1'($urandom_range(1));
            two    = 1'($urandom_range(1));
         end else begin
            sim_ms = sim_ms + $urandom_range(max_step);
            if (pick < 14) begin
               intent[0] = !intent[0];
               intent[1] = intent[0];
            end else begin
               if ($urandom_range(7) == 0) intent[0] = !intent[0];
               if ($urandom_range(7) == 0) intent[1] = !intent[1];
            end
            one = intent[0] ^ ($urandom_range(15) == 0) ^ press_cfg.invert_levels;
            two = intent[1] ^ ($urandom_range(15) == 0) ^ press_cfg.invert_levels;
         end
         push_poll(one, two, sim_ms);
      end
   endtask

   // Run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      press_cfg.debounce_ms    = DEBOUNCE_MS_RESET;
      press_cfg.long_press_ms  = LONG_PRESS_MS_RESET;
      press_cfg.both_window_ms = BOTH_WINDOW_MS_RESET;
      press_cfg.invert_levels  = 1'b0;
      for (int b = 0; b < 2; b++) begin
         debounced[b]  = 1'b0;
         prev_raw[b]   = 1'b0;
         armed[b]      = 1'b0;
         changed_at[b] = '0;
         pressed_at[b] = '0;
         intent[b]     = 1'b0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed polls at reset settings
      send_idle_pct = 26;
      recv_idle_pct = 56;
      push_poll(1'b1, 1'b0, 32'd0);            // change too soon after reset
      push_poll(1'b1, 1'b0, 32'd100);          // previous sample already high: held back
      push_poll(1'b0, 1'b0, 32'd120);          // release taken with no press seen: short one
      push_poll(1'b1, 1'b0, 32'd130);          // press held back inside debounce time
      push_poll(1'b0, 1'b0, 32'd400);          // short one
      push_poll(1'b0, 1'b1, 32'd500);
      push_poll(1'b0, 1'b0, 32'd700);          // short two
      push_poll(1'b1, 1'b0, 32'd1000);
      push_poll(1'b1, 1'b0, 32'd2000);         // hold equal to long time: nothing
      push_poll(1'b1, 1'b0, 32'd2001);         // long one
      push_poll(1'b0, 1'b0, 32'd2100);         // release of a consumed press
      push_poll(1'b1, 1'b0, 32'd3000);
      push_poll(1'b0, 1'b0, 32'd4000);         // release exactly at long time
      push_poll(1'b1, 1'b1, 32'd5000);
      push_poll(1'b1, 1'b1, 32'd6001);         // both long
      push_poll(1'b0, 1'b0, 32'd6100);
      push_poll(1'b1, 1'b0, 32'd7000);
      push_poll(1'b1, 1'b1, 32'd7300);
      push_poll(1'b1, 1'b1, 32'd8301);         // starts too far apart: no event
      push_poll(1'b0, 1'b0, 32'd8400);
      push_poll(1'b0, 1'b1, 32'd9000);
      push_poll(1'b0, 1'b1, 32'd10001);        // long two
      push_poll(1'b0, 1'b0, 32'hFFFF_FF00);
      push_poll(1'b1, 1'b0, 32'hFFFF_FFFF);    // press just before the time wraps
      push_poll(1'b0, 1'b0, 32'h0000_0100);    // short one across the wrap
      wait_until_drained();

      apply_settings(16'd5, 16'd40, 16'd10, 1'b0);
      queue_button_activity(90, 12);
      wait_until_drained();

      send_idle_pct = 56;
      recv_idle_pct = 26;
      apply_settings(16'd0, 16'd0, 16'd0, 1'b1);
      queue_button_activity(60, 3);
      wait_until_drained();

      apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      queue_button_activity(25, 40000);
      wait_until_drained();
      queue_button_activity(25, 40000);
      wait_until_drained();

      apply_settings(16'd3, 16'd25, 16'hFFFF, 1'b1);
      queue_button_activity(80, 8);
      wait_until_drained();

      // No idling; the receiver holds off long enough to back the block up
      send_idle_pct = 0;
      recv_idle_pct = 0;
      apply_settings(16'd2, 16'd30, 16'd8, 1'b0);
      queue_button_activity(120, 10);
      holds_asked++;
      wait_until_drained();

      repeat (10) @(posedge clock);
      if (failures == 0 && expected_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
